### hw/rtl/bgs_pkg.sv
// ----------------------------------------------------------------------------
// bgs_pkg
// Shared widths, codes and transfer structures of the bilinear grid sampler.
// ----------------------------------------------------------------------------
package bgs_pkg;

    // grid geometry, the grid side is a power of two
    localparam int GRID_LOG2 = 8;
    localparam int GRID_SIZE = 1 << GRID_LOG2;
    localparam int FRAC_BITS = 8;

    // field widths
    localparam int POS_W    = 24;
    localparam int SCALE_W  = 24;
    localparam int LIMIT_W  = 15;
    localparam int DATA_W   = 16;
    localparam int IDX_IN_W = 8;
    localparam int CFG_W    = 24;
    localparam int WORD_W   = 2 * DATA_W;

    // grid coordinate arithmetic
    localparam int GFRAC   = 24;
    localparam int PROD_W  = POS_W + SCALE_W + 1;
    localparam int G_W     = PROD_W + 1;
    localparam int CLAMP_W = GRID_LOG2 + GFRAC;

    // 2x2 banked storage
    localparam int NBANK  = 4;
    localparam int HALF_W = GRID_LOG2 - 1;
    localparam int ADDR_W = 2 * HALF_W;

    // blend arithmetic
    localparam int W_W   = 2 * FRAC_BITS + 1;
    localparam int MUL_W = DATA_W + W_W + 1;
    localparam int SUM_W = MUL_W + 2;

    // stages from accept to result register
    localparam int PIPE_DEPTH = 7;

    localparam logic signed [G_W-1:0] G_BIAS =
        G_W'(longint'(GRID_SIZE - 1) << (GFRAC - 1));
    localparam logic signed [G_W-1:0] G_HI =
        G_W'(longint'(GRID_SIZE - 1) << GFRAC);
    localparam logic signed [G_W-1:0] NEAR_CORR =
        G_W'((longint'(1) << GFRAC) - 1);

    typedef logic [1:0] t_op;
    localparam t_op OP_WRITE    = 2'd0;
    localparam t_op OP_BILINEAR = 2'd1;
    localparam t_op OP_NEAREST  = 2'd2;

    typedef logic t_cfg_idx;
    localparam t_cfg_idx CFG_SCALE = 1'b0;
    localparam t_cfg_idx CFG_LIMIT = 1'b1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32767);

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic [NBANK-1:0][W_W-1:0] weight;
        logic [NBANK-1:0]          corner_en;
        logic [NBANK-1:0][1:0]     bank_sel;
        logic                      bilinear;
    } t_blend;

    typedef struct packed {
        t_blend                     blend;
        logic [NBANK-1:0][ADDR_W-1:0] addr;
        logic [NBANK-1:0]           wr_en;
        t_word                      wdata;
    } t_req;

endpackage

### hw/rtl/bgs_ram.sv
// ----------------------------------------------------------------------------
// bgs_ram
// Single port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bgs_ram #(
    parameter int ADDR_W = 14,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic              i_we,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_addr];
        end
    end

endmodule

### hw/rtl/bgs_coord.sv
// ----------------------------------------------------------------------------
// bgs_coord
// Maps world coordinates to grid cells, weights and bank addresses.
// ----------------------------------------------------------------------------
module bgs_coord (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [bgs_pkg::SCALE_W-1:0]        i_scale,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  bgs_pkg::t_op                       i_operation,
    input  logic signed [bgs_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [bgs_pkg::POS_W-1:0]   i_pos_z,
    input  logic [bgs_pkg::IDX_IN_W-1:0]       i_entry_row,
    input  logic [bgs_pkg::IDX_IN_W-1:0]       i_entry_col,
    input  logic signed [bgs_pkg::DATA_W-1:0]  i_entry_distance,
    input  logic signed [bgs_pkg::DATA_W-1:0]  i_entry_height,
    output logic                               o_req_valid,
    output bgs_pkg::t_req                      o_req,
    input  logic                               i_req_take
);
    import bgs_pkg::*;

    localparam logic [FRAC_BITS:0] ONE_W = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [GRID_LOG2-1:0] IDX_MAX = GRID_LOG2'(GRID_SIZE - 1);

    function automatic logic [CLAMP_W-1:0] clamp_grid(input logic signed [G_W-1:0] g);
        logic [CLAMP_W-1:0] c;
        if (g < 0) begin
            c = '0;
        end else if (g > G_HI) begin
            c = G_HI[CLAMP_W-1:0];
        end else begin
            c = g[CLAMP_W-1:0];
        end
        return c;
    endfunction

    // truncate toward zero, low bits give the wrapped index
    function automatic logic [GRID_LOG2-1:0] near_index(input logic signed [G_W-1:0] g);
        logic signed [G_W-1:0] t;
        t = g + (g[G_W-1] ? NEAR_CORR : G_W'(0));
        return t[GFRAC +: GRID_LOG2];
    endfunction

    logic en_a, en_b, en_c;

    logic                      r_a_v;
    t_op                       r_a_op;
    logic signed [PROD_W-1:0]  r_a_px, r_a_pz;
    logic [IDX_IN_W-1:0]       r_a_row, r_a_col;
    t_word                     r_a_wdata;

    logic                      r_b_v;
    t_op                       r_b_op;
    logic signed [G_W-1:0]     r_b_gx, r_b_gz;
    logic [IDX_IN_W-1:0]       r_b_row, r_b_col;
    t_word                     r_b_wdata;

    logic                      r_c_v;
    t_req                      r_c_req;
    t_req                      n_c_req;

    assign en_c    = !r_c_v || i_req_take;
    assign en_b    = !r_b_v || en_c;
    assign en_a    = !r_a_v || en_b;
    assign o_ready = en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_v <= i_valid;
            end
            if (en_b) begin
                r_b_v <= r_a_v;
            end
            if (en_c) begin
                r_c_v <= r_b_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_valid) begin
            r_a_op    <= i_operation;
            r_a_px    <= i_pos_x * $signed({1'b0, i_scale});
            r_a_pz    <= i_pos_z * $signed({1'b0, i_scale});
            r_a_row   <= i_entry_row;
            r_a_col   <= i_entry_col;
            r_a_wdata <= {i_entry_height, i_entry_distance};
        end
        if (en_b && r_a_v) begin
            r_b_op    <= r_a_op;
            r_b_gx    <= G_W'(r_a_px) + G_BIAS;
            r_b_gz    <= G_W'(r_a_pz) + G_BIAS;
            r_b_row   <= r_a_row;
            r_b_col   <= r_a_col;
            r_b_wdata <= r_a_wdata;
        end
        if (en_c && r_b_v) begin
            r_c_req <= n_c_req;
        end
    end

    logic [CLAMP_W-1:0]   cx, cz;
    logic [GRID_LOG2-1:0] bx0, bx1, bz0, bz1;
    logic [GRID_LOG2-1:0] x0, x1, z0, z1, xinc, zinc;
    logic [FRAC_BITS-1:0] fa, fb;
    logic [FRAC_BITS:0]   oma, omb;
    logic                 in_range;
    logic [1:0][HALF_W-1:0] row_half, col_half;

    always_comb begin
        cx  = clamp_grid(r_b_gx);
        cz  = clamp_grid(r_b_gz);
        bx0 = cx[GFRAC +: GRID_LOG2];
        bz0 = cz[GFRAC +: GRID_LOG2];
        bx1 = (bx0 == IDX_MAX) ? bx0 : bx0 + GRID_LOG2'(1);
        bz1 = (bz0 == IDX_MAX) ? bz0 : bz0 + GRID_LOG2'(1);
        fa  = cx[GFRAC-1 -: FRAC_BITS];
        fb  = cz[GFRAC-1 -: FRAC_BITS];
        oma = ONE_W - {1'b0, fa};
        omb = ONE_W - {1'b0, fb};
        in_range = (32'(r_b_row) < GRID_SIZE) && (32'(r_b_col) < GRID_SIZE);

        n_c_req = '0;
        n_c_req.wdata = r_b_wdata;
        x0 = bx0;
        x1 = bx1;
        z0 = bz0;
        z1 = bz1;
        unique case (r_b_op)
            OP_BILINEAR: begin
                n_c_req.blend.bilinear  = 1'b1;
                n_c_req.blend.corner_en = '1;
                n_c_req.blend.weight[0] = W_W'(omb) * W_W'(oma);
                n_c_req.blend.weight[1] = W_W'(omb) * W_W'(fa);
                n_c_req.blend.weight[2] = W_W'(fb) * W_W'(oma);
                n_c_req.blend.weight[3] = W_W'(fb) * W_W'(fa);
            end
            OP_NEAREST: begin
                x0 = near_index(r_b_gx);
                z0 = near_index(r_b_gz);
                x1 = x0;
                z1 = z0;
                n_c_req.blend.corner_en = NBANK'(1);
                n_c_req.blend.weight[0] = W_W'(1) << (2 * FRAC_BITS);
            end
            OP_WRITE: begin
                x0 = GRID_LOG2'(r_b_col);
                z0 = GRID_LOG2'(r_b_row);
                x1 = x0;
                z1 = z0;
                for (int b = 0; b < NBANK; b++) begin
                    n_c_req.wr_en[b] = in_range && (2'(b) == {z0[0], x0[0]});
                end
            end
            default: begin
                n_c_req.blend.corner_en = '0;
            end
        endcase

        // even bank takes the even one of a pair of neighbors, odd bank the odd one
        xinc = x0 + GRID_LOG2'(1);
        zinc = z0 + GRID_LOG2'(1);
        row_half[0] = zinc[GRID_LOG2-1:1];
        row_half[1] = z0[GRID_LOG2-1:1];
        col_half[0] = xinc[GRID_LOG2-1:1];
        col_half[1] = x0[GRID_LOG2-1:1];
        for (int b = 0; b < NBANK; b++) begin
            n_c_req.addr[b] = {row_half[b / 2], col_half[b % 2]};
        end
        n_c_req.blend.bank_sel[0] = {z0[0], x0[0]};
        n_c_req.blend.bank_sel[1] = {z0[0], x1[0]};
        n_c_req.blend.bank_sel[2] = {z1[0], x0[0]};
        n_c_req.blend.bank_sel[3] = {z1[0], x1[0]};
    end

    assign o_req_valid = r_c_v;
    assign o_req       = r_c_req;

endmodule

### hw/rtl/bgs_blend.sv
// ----------------------------------------------------------------------------
// bgs_blend
// Weights the four neighbor entries, rounds, saturates and holds the result.
// ----------------------------------------------------------------------------
module bgs_blend (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [bgs_pkg::LIMIT_W-1:0]            i_limit,
    input  logic                                   i_valid,
    output logic                                   o_take,
    input  bgs_pkg::t_blend                        i_blend,
    input  logic [bgs_pkg::NBANK-1:0][bgs_pkg::WORD_W-1:0] i_bank,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [bgs_pkg::DATA_W-1:0]      o_distance,
    output logic signed [bgs_pkg::DATA_W-1:0]      o_height
);
    import bgs_pkg::*;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (2 * FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI     = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO     = SUM_W'(-32768);

    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] r;
        logic signed [DATA_W-1:0] v;
        r = (s + ROUND_HALF) >>> (2 * FRAC_BITS);
        if (r > SAT_HI) begin
            v = SAT_HI[DATA_W-1:0];
        end else if (r < SAT_LO) begin
            v = SAT_LO[DATA_W-1:0];
        end else begin
            v = r[DATA_W-1:0];
        end
        return v;
    endfunction

    logic en_e, en_f, en_o;

    logic                     r_e_v, r_f_v, r_o_v;
    logic                     r_e_bil, r_f_bil;
    logic signed [MUL_W-1:0]  r_e_pd [NBANK];
    logic signed [MUL_W-1:0]  r_e_ph [NBANK];
    logic signed [MUL_W-1:0]  n_e_pd [NBANK];
    logic signed [MUL_W-1:0]  n_e_ph [NBANK];
    logic signed [SUM_W-1:0]  r_f_sd, r_f_sh;
    logic signed [DATA_W-1:0] r_o_d, r_o_h;

    assign en_o   = !r_o_v || i_ready;
    assign en_f   = !r_f_v || en_o;
    assign en_e   = !r_e_v || en_f;
    assign o_take = en_e;

    always_comb begin
        t_word                    w;
        logic signed [DATA_W-1:0] fd, fh;
        for (int k = 0; k < NBANK; k++) begin
            w  = i_bank[i_blend.bank_sel[k]];
            fd = i_blend.corner_en[k] ? $signed(w[DATA_W-1:0]) : DATA_W'(0);
            fh = i_blend.corner_en[k] ? $signed(w[WORD_W-1:DATA_W]) : DATA_W'(0);
            n_e_pd[k] = fd * $signed({1'b0, i_blend.weight[k]});
            n_e_ph[k] = fh * $signed({1'b0, i_blend.weight[k]});
        end
    end

    logic signed [DATA_W-1:0] rd, rh;
    logic signed [DATA_W:0]   neg_limit;

    always_comb begin
        rd        = round_sat(r_f_sd);
        rh        = round_sat(r_f_sh);
        neg_limit = -$signed({2'b00, i_limit});
        if (r_f_bil && ($signed({rd[DATA_W-1], rd}) < neg_limit)) begin
            rd = $signed({1'b0, i_limit});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (en_e) begin
                r_e_v <= i_valid;
            end
            if (en_f) begin
                r_f_v <= r_e_v;
            end
            if (en_o) begin
                r_o_v <= r_f_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_e && i_valid) begin
            r_e_bil <= i_blend.bilinear;
            for (int k = 0; k < NBANK; k++) begin
                r_e_pd[k] <= n_e_pd[k];
                r_e_ph[k] <= n_e_ph[k];
            end
        end
        if (en_f && r_e_v) begin
            r_f_bil <= r_e_bil;
            r_f_sd  <= SUM_W'(r_e_pd[0]) + SUM_W'(r_e_pd[1])
                     + SUM_W'(r_e_pd[2]) + SUM_W'(r_e_pd[3]);
            r_f_sh  <= SUM_W'(r_e_ph[0]) + SUM_W'(r_e_ph[1])
                     + SUM_W'(r_e_ph[2]) + SUM_W'(r_e_ph[3]);
        end
        if (en_o && r_f_v) begin
            r_o_d <= rd;
            r_o_h <= rh;
        end
    end

    assign o_valid    = r_o_v;
    assign o_distance = r_o_d;
    assign o_height   = r_o_h;

endmodule

### hw/rtl/bilinear_grid_sampler.sv
// ----------------------------------------------------------------------------
// bilinear_grid_sampler
// Grid of (distance, height) entries with write, bilinear and nearest sampling.
//
// One item is taken every clock cycle while results are drained, and each
// item's result leaves from the blend result register. The rate comes from
// the grid storage: it is split into four RAM banks by row and column parity,
// so the four neighbors of a bilinear sample, a nearest lookup or an entry
// write each need one access per bank in the same cycle. Writes and reads go
// to the banks in item order at the same stage, so a sample always sees every
// earlier write. The grid holds no defined value after reset and there is no
// clearing pass; entries must be written before they are sampled. The scale
// and distance limit registers may be written only while the block is idle.
// ----------------------------------------------------------------------------
module bilinear_grid_sampler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  bgs_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [bgs_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  bgs_pkg::t_op                       i_operation,
    input  logic signed [bgs_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [bgs_pkg::POS_W-1:0]   i_pos_z,
    input  logic [bgs_pkg::IDX_IN_W-1:0]       i_entry_row,
    input  logic [bgs_pkg::IDX_IN_W-1:0]       i_entry_col,
    input  logic signed [bgs_pkg::DATA_W-1:0]  i_entry_distance,
    input  logic signed [bgs_pkg::DATA_W-1:0]  i_entry_height,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [bgs_pkg::DATA_W-1:0]  o_sampled_distance,
    output logic signed [bgs_pkg::DATA_W-1:0]  o_sampled_height
);
    import bgs_pkg::*;

    logic [SCALE_W-1:0] r_scale;
    logic [LIMIT_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                CFG_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
            endcase
        end
    end

    logic req_valid, req_take;
    t_req req;

    bgs_coord u_coord (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_scale          (r_scale),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_pos_x          (i_pos_x),
        .i_pos_z          (i_pos_z),
        .i_entry_row      (i_entry_row),
        .i_entry_col      (i_entry_col),
        .i_entry_distance (i_entry_distance),
        .i_entry_height   (i_entry_height),
        .o_req_valid      (req_valid),
        .o_req            (req),
        .i_req_take       (req_take)
    );

    // bank access stage
    logic   r_d_v;
    t_blend r_d_blend;
    logic   blend_take;
    logic   load_d;
    logic [NBANK-1:0][WORD_W-1:0] bank_q;

    assign req_take = !r_d_v || blend_take;
    assign load_d   = req_take && req_valid;

    for (genvar b = 0; b < NBANK; b++) begin : g_bank
        bgs_ram #(
            .ADDR_W (ADDR_W),
            .DATA_W (WORD_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_addr  (req.addr[b]),
            .i_we    (load_d && req.wr_en[b]),
            .i_wdata (req.wdata),
            .i_re    (load_d),
            .o_rdata (bank_q[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (req_take) begin
            r_d_v <= req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_d) begin
            r_d_blend <= req.blend;
        end
    end

    bgs_blend u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_limit    (r_limit),
        .i_valid    (r_d_v),
        .o_take     (blend_take),
        .i_blend    (r_d_blend),
        .i_bank     (bank_q),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_distance (o_sampled_distance),
        .o_height   (o_sampled_height)
    );

endmodule

### hw/rtl/bgs_checker.sv
// ----------------------------------------------------------------------------
// bgs_checker
// Port level checks of the grid sampler, bound to the top level.
// ----------------------------------------------------------------------------
module bgs_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic signed [bgs_pkg::DATA_W-1:0]  o_sampled_distance,
    input logic signed [bgs_pkg::DATA_W-1:0]  o_sampled_height
);
    import bgs_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

    logic [CNT_W-1:0] r_cnt;
    logic             in_xfer, out_xfer;

    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = o_valid && i_ready;

    // items in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CNT_W'(in_xfer) - CNT_W'(out_xfer);
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sampled_distance)
                                && $stable(o_sampled_height))
        else $error("stalled result changed");

    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != '0)
        else $error("result without an outstanding item");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CNT_W'(PIPE_DEPTH)) && !out_xfer |-> !o_ready)
        else $error("input taken with every stage occupied");

endmodule

bind bilinear_grid_sampler bgs_checker u_bgs_checker (.*);

### dv/bilinear_grid_sampler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_grid_sampler_tb
// Self-checking bench for the grid sampler. Write, bilinear and nearest
// transfers are driven in random bursts against a stalling result side,
// and a scoreboard class keeps its own copy of the grid and the registers
// to work out every expected distance and height. Each sample first loads
// any entry it would touch that has never been written. The run walks
// through several scale and distance limit settings, extremes included.
// ----------------------------------------------------------------------------
module bilinear_grid_sampler_tb;
    import bgs_pkg::*;

    localparam t_op    OP_NONE     = 2'd3;
    localparam int     POS_FRAC    = 8;
    localparam int     COORD_FRAC  = 24;
    localparam longint COORD_BIAS  = longint'(GRID_SIZE - 1) << (COORD_FRAC - 1);
    localparam longint COORD_TOP   = longint'(GRID_SIZE - 1) << COORD_FRAC;
    localparam longint UNIT_WEIGHT = longint'(1) << FRAC_BITS;
    localparam longint POS_HI      = (longint'(1) << (POS_W - 1)) - 1;
    localparam longint POS_LO      = -(longint'(1) << (POS_W - 1));
    localparam int     HOT_LO      = GRID_SIZE / 2 - 8;
    localparam int     HOT_HI      = GRID_SIZE / 2 + 7;

    typedef struct {
        t_op                       op;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_z;
        logic [IDX_IN_W-1:0]       row;
        logic [IDX_IN_W-1:0]       col;
        logic signed [DATA_W-1:0]  distance;
        logic signed [DATA_W-1:0]  height;
    } t_query;

    typedef struct {
        logic signed [DATA_W-1:0] distance;
        logic signed [DATA_W-1:0] height;
    } t_sample;

    class grid_scoreboard;
        logic signed [DATA_W-1:0] dist_mem [GRID_SIZE * GRID_SIZE];
        logic signed [DATA_W-1:0] height_mem [GRID_SIZE * GRID_SIZE];
        bit                       written [GRID_SIZE * GRID_SIZE];
        logic [SCALE_W-1:0]       scale;
        logic [LIMIT_W-1:0]       limit;
        t_sample                  expected_samples [$];
        int                       errors;

        function new();
            scale  = SCALE_RESET;
            limit  = LIMIT_RESET;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            if (idx == CFG_SCALE) scale = data[SCALE_W-1:0];
            else limit = data[LIMIT_W-1:0];
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        // world position to grid coordinate, 24 fraction bits
        function longint grid_coord(logic signed [POS_W-1:0] pos);
            return longint'(pos) * longint'(scale) + COORD_BIAS;
        endfunction

        function longint clamp_coord(longint g);
            if (g < 0) return 0;
            if (g > COORD_TOP) return COORD_TOP;
            return g;
        endfunction

        function int wrap_cell(longint g);
            longint t;
            t = (g >= 0) ? (g >>> COORD_FRAC) : -((-g) >>> COORD_FRAC);
            t = t % GRID_SIZE;
            if (t < 0) t += GRID_SIZE;
            return int'(t);
        endfunction

        function longint round_to_q88(longint s);
            longint r;
            r = (s + (longint'(1) << (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r;
        endfunction

        // cells a sample reads and their weights; nearest uses one full weight
        function void locate(input t_query q, output int idx[4], output longint wt[4]);
            longint gx, gz, a, b;
            int     x0, x1, z0, z1;
            gx = grid_coord(q.pos_x);
            gz = grid_coord(q.pos_z);
            if (q.op == OP_NEAREST) begin
                x0 = wrap_cell(gx);
                z0 = wrap_cell(gz);
                idx = '{default: z0 * GRID_SIZE + x0};
                wt = '{UNIT_WEIGHT * UNIT_WEIGHT, 0, 0, 0};
            end else begin
                gx = clamp_coord(gx);
                gz = clamp_coord(gz);
                x0 = int'(gx >>> COORD_FRAC);
                z0 = int'(gz >>> COORD_FRAC);
                x1 = (x0 + 1 < GRID_SIZE) ? x0 + 1 : GRID_SIZE - 1;
                z1 = (z0 + 1 < GRID_SIZE) ? z0 + 1 : GRID_SIZE - 1;
                a = (gx >>> (COORD_FRAC - FRAC_BITS)) & (UNIT_WEIGHT - 1);
                b = (gz >>> (COORD_FRAC - FRAC_BITS)) & (UNIT_WEIGHT - 1);
                idx[0] = z0 * GRID_SIZE + x0;
                idx[1] = z1 * GRID_SIZE + x0;
                idx[2] = z0 * GRID_SIZE + x1;
                idx[3] = z1 * GRID_SIZE + x1;
                wt[0] = (UNIT_WEIGHT - b) * (UNIT_WEIGHT - a);
                wt[1] = b * (UNIT_WEIGHT - a);
                wt[2] = (UNIT_WEIGHT - b) * a;
                wt[3] = b * a;
            end
        endfunction

        function void note_query(t_query q);
            int      idx[4];
            longint  wt[4];
            longint  sd, sh;
            int      entry_idx;
            t_sample e;
            e.distance = '0;
            e.height   = '0;
            if (q.op == OP_WRITE) begin
                entry_idx = int'(q.row) * GRID_SIZE + int'(q.col);
                dist_mem[entry_idx]   = q.distance;
                height_mem[entry_idx] = q.height;
                written[entry_idx]    = 1'b1;
            end else if (q.op == OP_BILINEAR || q.op == OP_NEAREST) begin
                locate(q, idx, wt);
                sd = 0;
                sh = 0;
                for (int k = 0; k < 4; k++) begin
                    sd += wt[k] * longint'(dist_mem[idx[k]]);
                    sh += wt[k] * longint'(height_mem[idx[k]]);
                end
                sd = round_to_q88(sd);
                sh = round_to_q88(sh);
                // below-range bilinear distance is replaced by the limit
                if (q.op == OP_BILINEAR && sd < -longint'(limit)) sd = longint'(limit);
                e.distance = DATA_W'(sd);
                e.height   = DATA_W'(sh);
            end
            expected_samples = {expected_samples, e};
        endfunction

        function void check_sample(logic signed [DATA_W-1:0] d, logic signed [DATA_W-1:0] h);
            t_sample e;
            if (expected_samples.size() == 0) begin
                $error("unexpected result transfer: sampled_distance %0d sampled_height %0d",
                       d, h);
                errors++;
            end else begin
                e = expected_samples.pop_front();
                if (d !== e.distance) begin
                    $error("sampled_distance: expected %0d, actual %0d", e.distance, d);
                    errors++;
                end
                if (h !== e.height) begin
                    $error("sampled_height: expected %0d, actual %0d", e.height, h);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    t_cfg_idx                  i_cfg_index = CFG_SCALE;
    logic [CFG_W-1:0]          i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    t_op                       i_operation = OP_WRITE;
    logic signed [POS_W-1:0]   i_pos_x = '0;
    logic signed [POS_W-1:0]   i_pos_z = '0;
    logic [IDX_IN_W-1:0]       i_entry_row = '0;
    logic [IDX_IN_W-1:0]       i_entry_col = '0;
    logic signed [DATA_W-1:0]  i_entry_distance = '0;
    logic signed [DATA_W-1:0]  i_entry_height = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic signed [DATA_W-1:0]  o_sampled_distance;
    logic signed [DATA_W-1:0]  o_sampled_height;

    grid_scoreboard board;
    int unsigned    items_sent = 0;
    int unsigned    burst_left = 0;
    int unsigned    rx_mode = 0;
    int unsigned    rx_left = 0;

    bilinear_grid_sampler u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_operation        (i_operation),
        .i_pos_x            (i_pos_x),
        .i_pos_z            (i_pos_z),
        .i_entry_row        (i_entry_row),
        .i_entry_col        (i_entry_col),
        .i_entry_distance   (i_entry_distance),
        .i_entry_height     (i_entry_height),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_sampled_distance (o_sampled_distance),
        .o_sampled_height   (o_sampled_height)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_sample(o_sampled_distance, o_sampled_height);
        end
    end

    // result side stalls on its own changing pattern
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(16, 300);
            end
            rx_left--;
            case (rx_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom);
                2: i_ready <= ($urandom_range(0, 3) == 0);
                default: i_ready <= (rx_left % 5) != 0;
            endcase
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_data();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // mostly positions that land on or near the grid for the current scale
    function automatic logic signed [POS_W-1:0] pick_pos(input logic [SCALE_W-1:0] scale);
        longint span, off, p;
        case ($urandom_range(0, 9))
            0, 1: span = 0;
            2, 3, 4: span = GRID_SIZE / 2 + 2;
            default: span = 6;
        endcase
        if (span == 0 || scale == 0) return POS_W'($urandom);
        off = (longint'($urandom_range(0, 2 * span * 256)) - span * 256)
              <<< (COORD_FRAC - POS_FRAC);
        p = off / longint'(scale);
        if (p > POS_HI) p = POS_HI;
        else if (p < POS_LO) p = POS_LO;
        return POS_W'(p);
    endfunction

    function automatic t_query random_query();
        t_query q;
        q.op       = t_op'($urandom_range(0, 3));
        q.pos_x    = POS_W'($urandom);
        q.pos_z    = POS_W'($urandom);
        q.row      = IDX_IN_W'($urandom);
        q.col      = IDX_IN_W'($urandom);
        q.distance = DATA_W'($urandom);
        q.height   = DATA_W'($urandom);
        return q;
    endfunction

    task automatic drive_query(input t_query q);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_valid          <= 1'b1;
        i_operation      <= q.op;
        i_pos_x          <= q.pos_x;
        i_pos_z          <= q.pos_z;
        i_entry_row      <= q.row;
        i_entry_col      <= q.col;
        i_entry_distance <= q.distance;
        i_entry_height   <= q.height;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_query(q);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic issue_write(input int entry_idx, input logic signed [DATA_W-1:0] d,
                               input logic signed [DATA_W-1:0] h);
        t_query q;
        q          = random_query();
        q.op       = OP_WRITE;
        q.row      = IDX_IN_W'(entry_idx / GRID_SIZE);
        q.col      = IDX_IN_W'(entry_idx % GRID_SIZE);
        q.distance = d;
        q.height   = h;
        drive_query(q);
    endtask

    // loads any never-written cell the sample touches, then sends the sample
    task automatic issue_sample(input t_op op, input logic signed [POS_W-1:0] x,
                                input logic signed [POS_W-1:0] z);
        t_query q;
        int     idx[4];
        longint wt[4];
        q       = random_query();
        q.op    = op;
        q.pos_x = x;
        q.pos_z = z;
        if (op == OP_BILINEAR || op == OP_NEAREST) begin
            board.locate(q, idx, wt);
            for (int k = 0; k < 4; k++) begin
                if (!board.written[idx[k]]) issue_write(idx[k], pick_data(), pick_data());
            end
        end
        drive_query(q);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, data);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 4) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] scale, input logic [CFG_W-1:0] limit,
                             input int unsigned n);
        int unsigned stop_at, pick, row, col;
        write_reg(CFG_SCALE, scale);
        write_reg(CFG_LIMIT, limit);
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 19);
            if (pick < 6) begin
                if ($urandom_range(0, 1)) begin
                    row = $urandom_range(HOT_LO, HOT_HI);
                    col = $urandom_range(HOT_LO, HOT_HI);
                end else begin
                    row = $urandom_range(0, GRID_SIZE - 1);
                    col = $urandom_range(0, GRID_SIZE - 1);
                end
                issue_write(row * GRID_SIZE + col, pick_data(), pick_data());
            end else if (pick < 12) begin
                issue_sample(OP_BILINEAR, pick_pos(board.scale), pick_pos(board.scale));
            end else if (pick < 18) begin
                issue_sample(OP_NEAREST, pick_pos(board.scale), pick_pos(board.scale));
            end else begin
                issue_sample(OP_NONE, pick_pos(board.scale), pick_pos(board.scale));
            end
        end
        settle();
    endtask

    initial begin
        board = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corners at the data extremes
        issue_write(0, 16'sh8000, 16'sh7fff);
        issue_write(GRID_SIZE * GRID_SIZE - 1, 16'sh7fff, 16'sh8000);
        // nearest exactly on cell zero
        issue_sample(OP_NEAREST, -24'sd32640, -24'sd32640);
        // far off grid both ways, clamped; low corner distance below the limit
        issue_sample(OP_BILINEAR, POS_W'(POS_LO), POS_W'(POS_LO));
        issue_sample(OP_BILINEAR, POS_W'(POS_HI), POS_W'(POS_HI));
        // grid center with half weights, then whole-cell weights
        issue_sample(OP_BILINEAR, '0, '0);
        issue_sample(OP_BILINEAR, 24'sd128, -24'sd128);
        // nearest with wrapped negative and large positive indices
        issue_sample(OP_NEAREST, POS_W'(POS_LO), POS_W'(POS_HI));
        issue_sample(OP_NEAREST, -24'sd32768, -24'sd33024);
        issue_sample(OP_NONE, POS_W'(POS_HI), POS_W'(POS_LO));
        settle();

        run_phase(CFG_W'(SCALE_RESET), CFG_W'(LIMIT_RESET), 250);
        run_phase(24'hffffff, '0, 250);
        run_phase('0, CFG_W'($urandom_range(0, 32767)), 150);
        run_phase(24'd1, CFG_W'(LIMIT_RESET), 150);
        run_phase(CFG_W'($urandom_range(4096, 1048576)), CFG_W'($urandom_range(0, 32767)), 350);
        run_phase(CFG_W'($urandom), CFG_W'($urandom_range(0, 512)), 350);

        if (board.errors == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### bilinear_grid_sampler.f
hw/rtl/bgs_pkg.sv
hw/rtl/bgs_ram.sv
hw/rtl/bgs_coord.sv
hw/rtl/bgs_blend.sv
hw/rtl/bilinear_grid_sampler.sv
hw/rtl/bgs_checker.sv
dv/bilinear_grid_sampler_tb.sv
